// File: rtl/core/msh_pkg.sv
// Shared constants, angle table and payload types for the magnetometer scale and heading block.
package msh_pkg;

  localparam int ITER = 16;
  localparam int TABLE_LEN = 24;
  localparam int STAGES = ITER + 2;

  localparam int AXIS_W = 16;
  localparam int SCALE_W = 16;
  localparam int SCALED_W = 32;
  localparam int XY_W = 36;
  localparam int Z_W = 24;
  localparam int HEAD_W = 15;
  localparam int FINE_SHIFT = 8;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd3768;
  localparam logic signed [Z_W-1:0] DEG180 = 24'sd2949120;
  localparam logic signed [Z_W-1:0] DEG360 = 24'sd5898240;
  localparam logic signed [Z_W-1:0] ROUND_HALF = 24'sd128;
  localparam logic [HEAD_W-1:0] HEADING_TURN = 15'd23040;

  localparam logic signed [Z_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
    24'sd737280, 24'sd435242, 24'sd229970, 24'sd116736,
    24'sd58595,  24'sd29326,  24'sd14667,  24'sd7334,
    24'sd3667,   24'sd1833,   24'sd917,    24'sd458,
    24'sd229,    24'sd115,    24'sd57,     24'sd29,
    24'sd14,     24'sd7,      24'sd4,      24'sd2,
    24'sd1,      24'sd0,      24'sd0,      24'sd0
  };

  typedef struct packed {
    logic signed [SCALED_W-1:0] x;
    logic signed [SCALED_W-1:0] y;
    logic signed [SCALED_W-1:0] z;
  } scaled_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
  } cordic_t;

endpackage

// File: rtl/core/magnetometer_sample_scale_and_heading.sv
// Top level of the magnetometer sample scaling and compass heading pipeline.
// One sample transfer is accepted every clock cycle while the input is not stalled, and each
// produces one result transfer through one input stage that does the three 16 x 17 bit scale
// multiplies, sixteen CORDIC stages with one micro-rotation each, and one output stage for the
// angle wrap and rounding.
// Every stage holds its own valid bit, so a stall on the output fills empty
// stages first and stalls the input only when all 18 stages hold samples.
// The scale register resets to 0.92 in Q4.12 and should be written only while
// the pipeline is empty.
module magnetometer_sample_scale_and_heading (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                scale_we,
  input  logic [msh_pkg::SCALE_W-1:0]         scale_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [47:0]                         raw_burst,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [msh_pkg::SCALED_W-1:0] scaled_x,
  output logic signed [msh_pkg::SCALED_W-1:0] scaled_y,
  output logic signed [msh_pkg::SCALED_W-1:0] scaled_z,
  output logic [msh_pkg::HEAD_W-1:0]          heading_deg
);

  logic [msh_pkg::SCALE_W-1:0] scale_factor;
  logic [msh_pkg::STAGES-1:0]  valid;
  logic [msh_pkg::STAGES-1:0]  valid_next;
  logic [msh_pkg::STAGES:0]    ready;

  msh_pkg::scaled_t front_scaled;
  msh_pkg::cordic_t front_vec;
  msh_pkg::scaled_t cordic_scaled;
  msh_pkg::cordic_t cordic_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= msh_pkg::SCALE_RESET;
    end else if (scale_we) begin
      scale_factor <= scale_wdata;
    end
  end

  assign ready[msh_pkg::STAGES] = !out_stall;

  for (genvar k = 0; k < msh_pkg::STAGES; k++) begin : g_ready
    assign ready[k] = !valid[k] || ready[k+1];
  end

  assign valid_next = {valid[msh_pkg::STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < msh_pkg::STAGES; k++) begin
        if (ready[k]) begin
          valid[k] <= valid_next[k];
        end
      end
    end
  end

  assign in_stall = !ready[0];
  assign out_valid = valid[msh_pkg::STAGES-1];

  msh_front u_front (
    .clk          (clk),
    .en           (ready[0]),
    .raw_burst    (raw_burst),
    .scale_factor (scale_factor),
    .scaled       (front_scaled),
    .vec          (front_vec)
  );

  msh_cordic u_cordic (
    .clk        (clk),
    .en         (ready[msh_pkg::ITER:1]),
    .vec_in     (front_vec),
    .scaled_in  (front_scaled),
    .vec_out    (cordic_vec),
    .scaled_out (cordic_scaled)
  );

  msh_heading u_heading (
    .clk         (clk),
    .en          (ready[msh_pkg::STAGES-1]),
    .vec         (cordic_vec),
    .scaled      (cordic_scaled),
    .scaled_x    (scaled_x),
    .scaled_y    (scaled_y),
    .scaled_z    (scaled_z),
    .heading_deg (heading_deg)
  );

  // The input stalls only when every stage already holds a sample.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&valid))
    else $error("input stalled while a pipeline stage is empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> valid[0])
    else $error("accepted sample did not enter the first stage");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading_deg < msh_pkg::HEADING_TURN))
    else $error("heading out of range");

  // Both scaled horizontal axes zero means a zero vector or a zero gain.
  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (scaled_x == '0) && (scaled_y == '0)) |-> (heading_deg == '0))
    else $error("zero vector gave a nonzero heading");

endmodule

// File: rtl/core/msh_front.sv
// Input stage: unpacks the burst, scales each axis and sets up the first heading rotation.
module msh_front (
  input  logic                          clk,
  input  logic                          en,
  input  logic [47:0]                   raw_burst,
  input  logic [msh_pkg::SCALE_W-1:0]   scale_factor,
  output msh_pkg::scaled_t              scaled,
  output msh_pkg::cordic_t              vec
);

  logic signed [msh_pkg::AXIS_W-1:0]   xr;
  logic signed [msh_pkg::AXIS_W-1:0]   yr;
  logic signed [msh_pkg::AXIS_W-1:0]   zr;
  logic signed [msh_pkg::SCALE_W:0]    scale_s;
  logic signed [msh_pkg::SCALED_W:0]   px;
  logic signed [msh_pkg::SCALED_W:0]   py;
  logic signed [msh_pkg::SCALED_W:0]   pz;
  logic signed [msh_pkg::XY_W-1:0]     x_ext;
  logic signed [msh_pkg::XY_W-1:0]     y_ext;
  msh_pkg::scaled_t                    scaled_next;
  msh_pkg::cordic_t                    vec_next;

  assign xr = raw_burst[47:32];
  assign zr = raw_burst[31:16];
  assign yr = raw_burst[15:0];
  assign scale_s = {1'b0, scale_factor};

  assign px = xr * scale_s;
  assign py = yr * scale_s;
  assign pz = zr * scale_s;

  assign x_ext = {{(msh_pkg::XY_W - msh_pkg::AXIS_W - 16){xr[msh_pkg::AXIS_W-1]}}, xr, 16'b0};
  assign y_ext = {{(msh_pkg::XY_W - msh_pkg::AXIS_W - 16){yr[msh_pkg::AXIS_W-1]}}, yr, 16'b0};

  always_comb begin
    scaled_next.x = px[msh_pkg::SCALED_W-1:0];
    scaled_next.y = py[msh_pkg::SCALED_W-1:0];
    scaled_next.z = pz[msh_pkg::SCALED_W-1:0];
    vec_next.zero = (scale_factor == '0) || ((xr == '0) && (yr == '0));
    if (xr[msh_pkg::AXIS_W-1]) begin
      vec_next.x = -x_ext;
      vec_next.y = -y_ext;
      vec_next.z = msh_pkg::DEG180;
    end else begin
      vec_next.x = x_ext;
      vec_next.y = y_ext;
      vec_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scaled <= scaled_next;
      vec <= vec_next;
    end
  end

endmodule

// File: rtl/core/msh_cordic.sv
// Vectoring CORDIC pipeline with one micro-rotation per register stage.
module msh_cordic (
  input  logic                       clk,
  input  logic [msh_pkg::ITER-1:0]   en,
  input  msh_pkg::cordic_t           vec_in,
  input  msh_pkg::scaled_t           scaled_in,
  output msh_pkg::cordic_t           vec_out,
  output msh_pkg::scaled_t           scaled_out
);

  msh_pkg::cordic_t vec_q    [msh_pkg::ITER];
  msh_pkg::scaled_t scaled_q [msh_pkg::ITER];

  for (genvar i = 0; i < msh_pkg::ITER; i++) begin : g_step
    msh_pkg::cordic_t             cur;
    msh_pkg::scaled_t             cur_s;
    msh_pkg::cordic_t             step_next;
    logic signed [msh_pkg::XY_W-1:0] xo;
    logic signed [msh_pkg::XY_W-1:0] yo;
    logic signed [msh_pkg::XY_W-1:0] dx;
    logic signed [msh_pkg::XY_W-1:0] dy;
    logic signed [msh_pkg::Z_W-1:0]  zo;

    if (i == 0) begin : g_first
      assign cur = vec_in;
      assign cur_s = scaled_in;
    end else begin : g_rest
      assign cur = vec_q[i-1];
      assign cur_s = scaled_q[i-1];
    end

    assign xo = cur.x;
    assign yo = cur.y;
    assign zo = cur.z;
    assign dx = yo >>> i;
    assign dy = xo >>> i;

    always_comb begin
      step_next.zero = cur.zero;
      if (!yo[msh_pkg::XY_W-1]) begin
        step_next.x = xo + dx;
        step_next.y = yo - dy;
        step_next.z = zo + msh_pkg::ATAN_TABLE[i];
      end else begin
        step_next.x = xo - dx;
        step_next.y = yo + dy;
        step_next.z = zo - msh_pkg::ATAN_TABLE[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        vec_q[i] <= step_next;
        scaled_q[i] <= cur_s;
      end
    end
  end

  assign vec_out = vec_q[msh_pkg::ITER-1];
  assign scaled_out = scaled_q[msh_pkg::ITER-1];

endmodule

// File: rtl/core/msh_heading.sv
// Output stage: wraps and rounds the angle to 1/64 degree and registers all result fields.
module msh_heading (
  input  logic                               clk,
  input  logic                               en,
  input  msh_pkg::cordic_t                   vec,
  input  msh_pkg::scaled_t                   scaled,
  output logic signed [msh_pkg::SCALED_W-1:0] scaled_x,
  output logic signed [msh_pkg::SCALED_W-1:0] scaled_y,
  output logic signed [msh_pkg::SCALED_W-1:0] scaled_z,
  output logic [msh_pkg::HEAD_W-1:0]         heading_deg
);

  logic signed [msh_pkg::Z_W-1:0] z_in;
  logic signed [msh_pkg::Z_W-1:0] z_adj;
  logic signed [msh_pkg::Z_W-1:0] z_round;
  logic [msh_pkg::HEAD_W-1:0]     head_raw;
  logic [msh_pkg::HEAD_W-1:0]     heading_next;

  assign z_in = vec.z;
  assign z_adj = z_in[msh_pkg::Z_W-1] ? z_in + msh_pkg::DEG360 : z_in;
  assign z_round = z_adj + msh_pkg::ROUND_HALF;
  assign head_raw = z_round[msh_pkg::HEAD_W+msh_pkg::FINE_SHIFT-1:msh_pkg::FINE_SHIFT];

  always_comb begin
    if (vec.zero || (head_raw >= msh_pkg::HEADING_TURN)) begin
      heading_next = '0;
    end else begin
      heading_next = head_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scaled_x <= scaled.x;
      scaled_y <= scaled.y;
      scaled_z <= scaled.z;
      heading_deg <= heading_next;
    end
  end

endmodule

// File: verif/tb_magnetometer_sample_scale_and_heading.sv
// Self-checking testbench for the magnetometer scale and compass heading pipeline.
`timescale 1ns / 1ps

module tb_magnetometer_sample_scale_and_heading;

  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 68;
  localparam int DIRECTED_ROWS = 22;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int READING_W = 3 * msh_pkg::SCALED_W + msh_pkg::HEAD_W;

  typedef struct packed {
    logic signed [msh_pkg::SCALED_W-1:0] x;
    logic signed [msh_pkg::SCALED_W-1:0] y;
    logic signed [msh_pkg::SCALED_W-1:0] z;
    logic [msh_pkg::HEAD_W-1:0]          heading;
  } reading_t;

  typedef struct packed {
    logic [47:0] raw;
    logic        typed;
    reading_t    want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic scale_we = 1'b0;
  logic [msh_pkg::SCALE_W-1:0] scale_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [47:0] raw_burst = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [msh_pkg::SCALED_W-1:0] scaled_x;
  logic signed [msh_pkg::SCALED_W-1:0] scaled_y;
  logic signed [msh_pkg::SCALED_W-1:0] scaled_z;
  logic [msh_pkg::HEAD_W-1:0] heading_deg;

  reading_t pending_readings [$];
  logic [msh_pkg::SCALE_W-1:0] gain = msh_pkg::SCALE_RESET;
  int mismatches = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;

  // Rows with a typed result are zero vectors, where the heading is 0 by definition.
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    {48'h0000_0000_0000, 1'b1, 32'sd0, 32'sd0, 32'sd0, 15'd0},
    {48'h0000_7FFF_0000, 1'b1, 32'sd0, 32'sd0, 32'sd123466056, 15'd0},
    {48'h0000_8000_0000, 1'b1, 32'sd0, 32'sd0, -32'sd123469824, 15'd0},
    {48'h7FFF_0000_0000, 1'b0, {READING_W{1'b0}}},
    {48'h8000_0000_0000, 1'b0, {READING_W{1'b0}}},
    {48'h0000_0000_7FFF, 1'b0, {READING_W{1'b0}}},
    {48'h0000_0000_8000, 1'b0, {READING_W{1'b0}}},
    {48'h7FFF_1234_7FFF, 1'b0, {READING_W{1'b0}}},
    {48'h8000_FFFF_8000, 1'b0, {READING_W{1'b0}}},
    {48'h7FFF_0001_8000, 1'b0, {READING_W{1'b0}}},
    {48'h8000_8000_7FFF, 1'b0, {READING_W{1'b0}}},
    {48'h0001_0000_0000, 1'b0, {READING_W{1'b0}}},
    {48'hFFFF_0000_0000, 1'b0, {READING_W{1'b0}}},
    {48'h0000_0000_0001, 1'b0, {READING_W{1'b0}}},
    {48'h0000_0000_FFFF, 1'b0, {READING_W{1'b0}}},
    {48'h7FFF_0000_FFFF, 1'b0, {READING_W{1'b0}}},
    {48'hFFFF_0000_7FFF, 1'b0, {READING_W{1'b0}}},
    {48'h8000_0000_FFFF, 1'b0, {READING_W{1'b0}}},
    {48'h8000_0000_0001, 1'b0, {READING_W{1'b0}}},
    {48'hFFFF_FFFF_FFFF, 1'b0, {READING_W{1'b0}}},
    {48'h7FFF_8000_0001, 1'b0, {READING_W{1'b0}}},
    {48'h8000_7FFF_FFFF, 1'b0, {READING_W{1'b0}}}
  };

  magnetometer_sample_scale_and_heading uut (
    .clk         (clk),
    .rst         (rst),
    .scale_we    (scale_we),
    .scale_wdata (scale_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .raw_burst   (raw_burst),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scaled_x    (scaled_x),
    .scaled_y    (scaled_y),
    .scaled_z    (scaled_z),
    .heading_deg (heading_deg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic reading_t scale_and_heading(input logic [47:0] raw,
                                                 input logic [msh_pkg::SCALE_W-1:0] s);
    reading_t r;
    longint sl, xr, yr, zr, x, y, z, dx, dy, h;
    sl = longint'(s);
    xr = longint'($signed(raw[47:32]));
    zr = longint'($signed(raw[31:16]));
    yr = longint'($signed(raw[15:0]));
    r.x = 32'(xr * sl);
    r.y = 32'(yr * sl);
    r.z = 32'(zr * sl);
    r.heading = '0;
    if (sl != 0 && !(xr == 0 && yr == 0)) begin
      x = xr * 65536;
      y = yr * 65536;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = longint'(msh_pkg::DEG180);
      end
      for (int i = 0; i < msh_pkg::ITER && i < msh_pkg::TABLE_LEN; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(msh_pkg::ATAN_TABLE[i]);
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(msh_pkg::ATAN_TABLE[i]);
        end
      end
      if (z < 0) z = z + longint'(msh_pkg::DEG360);
      if (z < 0) z = 0;
      h = (z + longint'(msh_pkg::ROUND_HALF)) >>> msh_pkg::FINE_SHIFT;
      while (h >= longint'(msh_pkg::HEADING_TURN)) h = h - longint'(msh_pkg::HEADING_TURN);
      r.heading = h[msh_pkg::HEAD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 9))
      0: rand_axis = 16'h0000;
      1: rand_axis = 16'h7FFF;
      2: rand_axis = 16'h8000;
      3: rand_axis = 16'hFFFF;
      4: rand_axis = 16'h0001;
      default: rand_axis = 16'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("tb: mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic send_sample(input logic [47:0] raw, input logic typed, input reading_t want);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid = 1'b1;
    raw_burst = raw;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(typed ? want : scale_and_heading(raw, gain));
    @(negedge clk);
  endtask

  task automatic drain_pipeline();
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_scale(input logic [msh_pkg::SCALE_W-1:0] value);
    drain_pipeline();
    scale_we = 1'b1;
    scale_wdata = value;
    @(negedge clk);
    scale_we = 1'b0;
    gain = value;
  endtask

  always @(negedge clk) begin
    if (rst || !receiver_idles) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        flag_mismatch("result transfer with nothing pending");
      end else begin
        want = pending_readings.pop_front();
        if (scaled_x !== want.x)
          flag_mismatch($sformatf("scaled_x got %0d want %0d", scaled_x, want.x));
        if (scaled_y !== want.y)
          flag_mismatch($sformatf("scaled_y got %0d want %0d", scaled_y, want.y));
        if (scaled_z !== want.z)
          flag_mismatch($sformatf("scaled_z got %0d want %0d", scaled_z, want.z));
        if (heading_deg !== want.heading)
          flag_mismatch($sformatf("heading_deg got %0d want %0d", heading_deg, want.heading));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [msh_pkg::SCALE_W-1:0] phase_scale [PHASES];
    logic [47:0] raw;
    phase_scale = '{16'd0, 16'hFFFF, 16'd1, 16'd4096, 16'd0, 16'd0, msh_pkg::SCALE_RESET};
    phase_scale[4] = 16'($urandom);
    phase_scale[5] = 16'($urandom);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_sample(directed_rows[i].raw, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
      end
      load_scale(phase_scale[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 2 && n == ITEMS_PER_PHASE / 2) drain_pipeline();
        raw = {rand_axis(), rand_axis(), rand_axis()};
        if ($urandom_range(0, 19) == 0) begin
          raw[47:32] = '0;
          raw[15:0] = '0;
        end
        send_sample(raw, 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (2 * msh_pkg::STAGES + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
